// ===== sv/jsu_pkg.sv =====
// Shared result codes and the result record type of the JSON string unescape unit.
`default_nettype none
package jsu_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_EXPECTED_QUOTE = 3'd0;
  localparam logic [2:0] ERR_BAD_ESCAPE     = 3'd1;
  localparam logic [2:0] ERR_BAD_UNICODE    = 3'd2;
  localparam logic [2:0] ERR_CONTROL_BYTE   = 3'd3;
  localparam logic [2:0] ERR_UNTERMINATED   = 3'd4;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/jsu_in_if.sv =====
// Input channel carrying commands and raw source bytes.
`default_nettype none
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;

  modport source (output valid, output command, output in_byte, input ready);
  modport sink (input valid, input command, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/jsu_out_if.sv =====
// Output channel carrying decoded bytes, close markers and errors.
`default_nettype none
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink (input valid, input kind, input out_byte, input error_code,
                input last, output ready);
endinterface
`default_nettype wire

// ===== sv/json_string_unescape_utf8_unit.sv =====
// JSON string unescaper with UTF-8 encoding of \u escapes, one source byte per transfer.
// Latency: the first result of an input transfer is offered in the cycle after it.
// Throughput: one input transfer per cycle while each gives at most one result and dst is
// ready; a \u escape that gives two or three bytes holds input until the last is taken.
// Reset is synchronous: the decoder returns to idle and any pending results are dropped.
`default_nettype none
module json_string_unescape_utf8_unit (
  input  wire logic clk,
  input  wire logic rst,
  jsu_in_if.sink    src,
  jsu_out_if.source dst
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_DONE = 3'd4,
    MODE_FAIL = 3'd5
  } mode_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  mode_t       mode;
  mode_t       mode_next;
  logic [1:0]  hex_count;
  logic [1:0]  hex_count_next;
  logic [15:0] code_point;
  logic [15:0] code_point_next;
  logic [15:0] cp_new;
  logic [4:0]  hv;

  res_t        ent [MAX_RESULTS];
  res_t        ent_next [MAX_RESULTS];
  logic [1:0]  n_res;
  logic [1:0]  rem;
  logic [1:0]  pos;

  logic        accept;
  logic        deliver;

  assign accept  = src.valid && src.ready;
  assign deliver = dst.valid && dst.ready;
  assign src.ready = (rem == 2'd0) || (rem == 2'd1 && dst.ready);

  assign dst.valid      = (rem != 2'd0);
  assign dst.kind       = ent[pos].kind;
  assign dst.out_byte   = ent[pos].out_byte;
  assign dst.error_code = ent[pos].error_code;
  assign dst.last       = (rem == 2'd1);

  assign hv     = hex_val(src.in_byte);
  assign cp_new = {code_point[11:0], hv[3:0]};

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    n_res           = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      ent_next[i] = '{kind: KIND_BYTE, out_byte: 8'h00, error_code: 3'd0};
    end
    if (src.command == CMD_END) begin
      case (mode)
        MODE_IDLE: begin
          n_res = 2'd1;
          ent_next[0] = '{kind: KIND_ERROR, out_byte: 8'h00, error_code: ERR_EXPECTED_QUOTE};
        end
        MODE_STR: begin
          n_res = 2'd1;
          ent_next[0] = '{kind: KIND_ERROR, out_byte: 8'h00, error_code: ERR_UNTERMINATED};
        end
        MODE_ESC: begin
          n_res = 2'd1;
          ent_next[0] = '{kind: KIND_ERROR, out_byte: 8'h00, error_code: ERR_BAD_ESCAPE};
        end
        MODE_HEX: begin
          n_res = 2'd1;
          ent_next[0] = '{kind: KIND_ERROR, out_byte: 8'h00, error_code: ERR_BAD_UNICODE};
        end
        default: begin
        end
      endcase
      mode_next       = MODE_IDLE;
      hex_count_next  = 2'd0;
      code_point_next = 16'h0000;
    end else begin
      case (mode)
        MODE_IDLE: begin
          if (src.in_byte == CH_QUOTE) begin
            mode_next = MODE_STR;
          end else begin
            n_res = 2'd1;
            ent_next[0] = '{kind: KIND_ERROR, out_byte: 8'h00,
                            error_code: ERR_EXPECTED_QUOTE};
            mode_next = MODE_FAIL;
          end
        end
        MODE_STR: begin
          if (src.in_byte == CH_QUOTE) begin
            n_res = 2'd1;
            ent_next[0] = '{kind: KIND_CLOSE, out_byte: 8'h00, error_code: 3'd0};
            mode_next = MODE_DONE;
          end else if (src.in_byte == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
          end else if (src.in_byte < CH_SPACE) begin
            n_res = 2'd1;
            ent_next[0] = '{kind: KIND_ERROR, out_byte: 8'h00,
                            error_code: ERR_CONTROL_BYTE};
            mode_next = MODE_FAIL;
          end else begin
            n_res = 2'd1;
            ent_next[0] = '{kind: KIND_BYTE, out_byte: src.in_byte, error_code: 3'd0};
          end
        end
        MODE_ESC: begin
          n_res = 2'd1;
          mode_next = MODE_STR;
          case (src.in_byte)
            CH_QUOTE:     ent_next[0].out_byte = 8'h22;
            CH_BACKSLASH: ent_next[0].out_byte = 8'h5c;
            CH_SLASH:     ent_next[0].out_byte = 8'h2f;
            CH_B:         ent_next[0].out_byte = 8'h08;
            CH_F:         ent_next[0].out_byte = 8'h0c;
            CH_N:         ent_next[0].out_byte = 8'h0a;
            CH_R:         ent_next[0].out_byte = 8'h0d;
            CH_T:         ent_next[0].out_byte = 8'h09;
            CH_U: begin
              n_res           = 2'd0;
              mode_next       = MODE_HEX;
              hex_count_next  = 2'd0;
              code_point_next = 16'h0000;
            end
            default: begin
              ent_next[0] = '{kind: KIND_ERROR, out_byte: 8'h00,
                              error_code: ERR_BAD_ESCAPE};
              mode_next = MODE_FAIL;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hv[4]) begin
            n_res = 2'd1;
            ent_next[0] = '{kind: KIND_ERROR, out_byte: 8'h00,
                            error_code: ERR_BAD_UNICODE};
            mode_next = MODE_FAIL;
          end else if (hex_count == 2'd3) begin
            if (cp_new <= 16'h007f) begin
              n_res = 2'd1;
              ent_next[0].out_byte = cp_new[7:0];
            end else if (cp_new <= 16'h07ff) begin
              n_res = 2'd2;
              ent_next[0].out_byte = 8'hc0 | {3'b000, cp_new[10:6]};
              ent_next[1].out_byte = 8'h80 | {2'b00, cp_new[5:0]};
            end else begin
              n_res = 2'd3;
              ent_next[0].out_byte = 8'he0 | {4'h0, cp_new[15:12]};
              ent_next[1].out_byte = 8'h80 | {2'b00, cp_new[11:6]};
              ent_next[2].out_byte = 8'h80 | {2'b00, cp_new[5:0]};
            end
            hex_count_next  = 2'd0;
            code_point_next = 16'h0000;
            mode_next       = MODE_STR;
          end else begin
            code_point_next = cp_new;
            hex_count_next  = hex_count + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_count  <= 2'd0;
      code_point <= 16'h0000;
      rem        <= 2'd0;
      pos        <= 2'd0;
    end else if (accept) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
      rem        <= n_res;
      pos        <= 2'd0;
    end else if (deliver) begin
      rem <= rem - 2'd1;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        ent[i] <= ent_next[i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rem} + {1'b0, pos}) <= 3'd3)
    else $error("Pending results run past the result buffer.");

  a_single_non_byte: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && dst.kind != KIND_BYTE) |-> (dst.last && pos == 2'd0))
    else $error("A close or error result is not the only result of its transfer.");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && src.command == CMD_END) |=>
      (mode == MODE_IDLE && hex_count == 2'd0 && code_point == 16'h0000))
    else $error("End of source did not return the decoder to idle.");

  a_hex_only_in_digits: assert property (@(posedge clk) disable iff (rst)
    (hex_count != 2'd0) |-> (mode == MODE_HEX || mode == MODE_FAIL))
    else $error("Hex digit count is set outside a unicode escape.");
`endif

endmodule
`default_nettype wire

// ===== verif/unescape_checker.sv =====
// Checker that predicts the decoded results of the JSON string unescaper and compares them.
`timescale 1ns / 100ps
module unescape_checker (
  input wire logic clk,
  input wire logic rst,
  jsu_in_if        src,
  jsu_out_if       dst,
  output int       fail_count,
  output int       pending
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef enum logic [2:0] {
    S_IDLE, S_TEXT, S_ESCAPE, S_HEX, S_CLOSED, S_FAILED
  } scan_state_t;

  typedef struct packed {
    res_t res;
    logic last;
  } decoded_t;

  scan_state_t state;
  logic [1:0]  hex_count;
  logic [15:0] code_point;
  decoded_t    decoded_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic res_t make_res(logic [1:0] kind, logic [7:0] value, logic [2:0] code);
    res_t r;
    r.kind = kind;
    r.out_byte = value;
    r.error_code = code;
    return r;
  endfunction

  task automatic unescape_step(input logic cmd, input logic [7:0] c);
    res_t        batch[$];
    decoded_t    d;
    logic [3:0]  nib;
    logic [15:0] cp;
    logic [7:0]  esc;
    bit          ok;
    if (cmd == CMD_END) begin
      case (state)
        S_IDLE: batch.push_back(make_res(KIND_ERROR, 8'h00, ERR_EXPECTED_QUOTE));
        S_TEXT: batch.push_back(make_res(KIND_ERROR, 8'h00, ERR_UNTERMINATED));
        S_ESCAPE: batch.push_back(make_res(KIND_ERROR, 8'h00, ERR_BAD_ESCAPE));
        S_HEX: batch.push_back(make_res(KIND_ERROR, 8'h00, ERR_BAD_UNICODE));
        default: ;
      endcase
      state = S_IDLE;
      hex_count = 2'd0;
      code_point = 16'h0000;
    end else begin
      case (state)
        S_IDLE: begin
          if (c == CH_QUOTE) begin
            state = S_TEXT;
          end else begin
            batch.push_back(make_res(KIND_ERROR, 8'h00, ERR_EXPECTED_QUOTE));
            state = S_FAILED;
          end
        end
        S_TEXT: begin
          if (c == CH_QUOTE) begin
            batch.push_back(make_res(KIND_CLOSE, 8'h00, 3'd0));
            state = S_CLOSED;
          end else if (c == CH_BSLASH) begin
            state = S_ESCAPE;
          end else if (c < 8'h20) begin
            batch.push_back(make_res(KIND_ERROR, 8'h00, ERR_CONTROL_BYTE));
            state = S_FAILED;
          end else begin
            batch.push_back(make_res(KIND_BYTE, c, 3'd0));
          end
        end
        S_ESCAPE: begin
          ok = 1'b1;
          esc = 8'h00;
          case (c)
            CH_QUOTE: esc = 8'h22;
            CH_BSLASH: esc = 8'h5c;
            "/": esc = 8'h2f;
            "b": esc = 8'h08;
            "f": esc = 8'h0c;
            "n": esc = 8'h0a;
            "r": esc = 8'h0d;
            "t": esc = 8'h09;
            default: ok = 1'b0;
          endcase
          if (ok) begin
            batch.push_back(make_res(KIND_BYTE, esc, 3'd0));
            state = S_TEXT;
          end else if (c == "u") begin
            state = S_HEX;
            hex_count = 2'd0;
            code_point = 16'h0000;
          end else begin
            batch.push_back(make_res(KIND_ERROR, 8'h00, ERR_BAD_ESCAPE));
            state = S_FAILED;
          end
        end
        S_HEX: begin
          ok = 1'b1;
          nib = 4'h0;
          if (c >= "0" && c <= "9") nib = 4'(c - "0");
          else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
          else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
          else ok = 1'b0;
          if (!ok) begin
            batch.push_back(make_res(KIND_ERROR, 8'h00, ERR_BAD_UNICODE));
            state = S_FAILED;
          end else begin
            code_point = {code_point[11:0], nib};
            if (hex_count == 2'd3) begin
              cp = code_point;
              if (cp <= 16'h007f) begin
                batch.push_back(make_res(KIND_BYTE, cp[7:0], 3'd0));
              end else if (cp <= 16'h07ff) begin
                batch.push_back(make_res(KIND_BYTE, {3'b110, cp[10:6]}, 3'd0));
                batch.push_back(make_res(KIND_BYTE, {2'b10, cp[5:0]}, 3'd0));
              end else begin
                batch.push_back(make_res(KIND_BYTE, {4'b1110, cp[15:12]}, 3'd0));
                batch.push_back(make_res(KIND_BYTE, {2'b10, cp[11:6]}, 3'd0));
                batch.push_back(make_res(KIND_BYTE, {2'b10, cp[5:0]}, 3'd0));
              end
              hex_count = 2'd0;
              code_point = 16'h0000;
              state = S_TEXT;
            end else begin
              hex_count = hex_count + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
    foreach (batch[i]) begin
      d.res = batch[i];
      d.last = (i == batch.size() - 1);
      decoded_q.push_back(d);
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      state = S_IDLE;
      hex_count = 2'd0;
      code_point = 16'h0000;
      decoded_q.delete();
    end else begin
      if (dst.valid && dst.ready) begin
        if (decoded_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: kind=%0d byte=%02h code=%0d last=%0b",
                     dst.kind, dst.out_byte, dst.error_code, dst.last);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (dst.kind !== want.res.kind || dst.out_byte !== want.res.out_byte ||
              dst.error_code !== want.res.error_code || dst.last !== want.last) begin
            if (fail_count < 10)
              $display("mismatch: expected kind=%0d byte=%02h code=%0d last=%0b, %s",
                       want.res.kind, want.res.out_byte, want.res.error_code, want.last,
                       $sformatf("got kind=%0d byte=%02h code=%0d last=%0b",
                                 dst.kind, dst.out_byte, dst.error_code, dst.last));
            fail_count++;
          end
        end
      end
      if (src.valid && src.ready) unescape_step(src.command, src.in_byte);
    end
    pending <= decoded_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the JSON string unescaper: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module tb;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT = 100000;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  logic clk;
  logic rst;
  bit   quiet;
  int   cycles = 0;
  int   items = 0;
  int   chk_fails;
  int   chk_pending;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_unit dut (
    .clk (clk),
    .rst (rst),
    .src (in_ch),
    .dst (out_ch)
  );

  unescape_checker chk (
    .clk        (clk),
    .rst        (rst),
    .src        (in_ch),
    .dst        (out_ch),
    .fail_count (chk_fails),
    .pending    (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= quiet || $urandom_range(0, 99) >= 23;

  task automatic send(input logic cmd, input logic [7:0] value, input bit live = 1'b1);
    while (!quiet && $urandom_range(0, 99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.in_byte <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (live) items++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
  endfunction

  task automatic send_unicode(input logic [15:0] cp, input int digits);
    send(CMD_BYTE, CH_BSLASH);
    send(CMD_BYTE, "u");
    for (int i = 0; i < digits; i++)
      send(CMD_BYTE, hex_char(cp[15 - 4 * i -: 4], $urandom_range(0, 1)));
  endtask

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 16'h007f));
      1: return 16'($urandom_range(16'h0080, 16'h07ff));
      2: return 16'($urandom_range(16'h0800, 16'hffff));
      3: return 16'h0000;
      4: begin
        case ($urandom_range(0, 5))
          0: return 16'h007f;
          1: return 16'h0080;
          2: return 16'h07ff;
          3: return 16'h0800;
          4: return 16'hffff;
          default: return 16'hd83d;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'hff)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  initial begin
    int         n;
    logic [7:0] c;
    rst = 1'b1;
    quiet = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_BYTE;
    in_ch.in_byte = 8'h00;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every end-of-source case, idle and ignored bytes, widest \u escape.
    send(CMD_END, 8'hff);
    send(CMD_BYTE, "x");
    send(CMD_BYTE, 8'h00);
    send(CMD_END, 8'h00);
    send(CMD_BYTE, CH_QUOTE);
    send(CMD_BYTE, 8'hff);
    send_unicode(16'hffff, 4);
    send(CMD_BYTE, CH_QUOTE);
    send(CMD_BYTE, "#");
    send(CMD_END, 8'h00);
    send(CMD_BYTE, CH_QUOTE);
    send(CMD_BYTE, CH_BSLASH);
    send(CMD_END, 8'h00);
    send(CMD_BYTE, CH_QUOTE);
    send_unicode(16'h1000, 1);
    send(CMD_END, 8'h00);
    send(CMD_BYTE, CH_QUOTE);
    send(CMD_BYTE, 8'h1f);
    send(CMD_END, 8'h00);
    send(CMD_BYTE, CH_QUOTE);
    send(CMD_END, 8'h00);
    wait_drain();

    items = 0;
    while (items < RANDOM_ITEMS) begin
      quiet = (items >= 90 && items < 150);
      case ($urandom_range(0, 99)) inside
        [0:69]: begin
          send(CMD_BYTE, CH_QUOTE);
          n = $urandom_range(0, 8);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0, 1: send(CMD_BYTE, pick_plain());
              2: begin
                send(CMD_BYTE, CH_BSLASH);
                case ($urandom_range(0, 7))
                  0: send(CMD_BYTE, CH_QUOTE);
                  1: send(CMD_BYTE, CH_BSLASH);
                  2: send(CMD_BYTE, "/");
                  3: send(CMD_BYTE, "b");
                  4: send(CMD_BYTE, "f");
                  5: send(CMD_BYTE, "n");
                  6: send(CMD_BYTE, "r");
                  default: send(CMD_BYTE, "t");
                endcase
              end
              default: send_unicode(pick_code_point(), 4);
            endcase
          end
          send(CMD_BYTE, CH_QUOTE);
          if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 2)) send(CMD_BYTE, 8'($urandom), 1'b0);
          send(CMD_END, 8'($urandom));
        end
        [70:84]: begin
          send(CMD_BYTE, CH_QUOTE);
          repeat ($urandom_range(0, 3)) send(CMD_BYTE, pick_plain());
          case ($urandom_range(0, 5))
            0: send(CMD_BYTE, 8'($urandom_range(0, 8'h1f)));
            1: begin
              send(CMD_BYTE, CH_BSLASH);
              do c = 8'($urandom);
              while (c == CH_QUOTE || c == CH_BSLASH || c == "/" || c == "b" || c == "f" ||
                     c == "n" || c == "r" || c == "t" || c == "u");
              send(CMD_BYTE, c);
            end
            2: begin
              send_unicode(pick_code_point(), $urandom_range(0, 3));
              do c = 8'($urandom);
              while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                     (c >= "A" && c <= "F"));
              send(CMD_BYTE, c);
            end
            3: ;
            4: send(CMD_BYTE, CH_BSLASH);
            default: send_unicode(pick_code_point(), $urandom_range(0, 3));
          endcase
          send(CMD_END, 8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
              0, 1: c = CH_QUOTE;
              2: c = CH_BSLASH;
              default: c = 8'($urandom);
            endcase
            send(($urandom_range(0, 4) == 0) ? CMD_END : CMD_BYTE, c);
          end
        end
      endcase
    end
    quiet = 1'b0;

    wait_drain();
    repeat (8) @(posedge clk);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
